/* hw/rtl/kst_pkg.sv */
package kst_pkg;

   // list geometry
   localparam int KEEP_COUNT = 5;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

   // sum of all entries never overflows this width
   localparam int SUM_W      = DATA_W + $clog2(KEEP_COUNT) + 1;

   // divide-by-count unit: DIV_BITS quotient bits per cycle
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIVD_W     = DIV_STEPS * DIV_BITS;
   localparam int STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int REM_W      = $clog2(KEEP_COUNT + 1);

   // sentinel fill values in mm
   localparam int SENTINEL_BASE_MM = 1000000000;
   localparam int SENTINEL_STEP_MM = 1000;

   // request operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   // sequencer to list unit
   typedef struct packed {
      logic             start;
      logic             step;
      logic [IDX_W-1:0] idx;
   } list_ctrl_type;

   function automatic logic signed [DATA_W-1:0] sentinel(input logic [IDX_W-1:0] i);
      return DATA_W'(SENTINEL_BASE_MM + SENTINEL_STEP_MM * int'(i));
   endfunction

endpackage

/* hw/rtl/kst_req_if.sv */
interface kst_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [kst_pkg::DATA_W-1:0]   point_x_mm;

   modport source (output valid, output operation, output point_x_mm, input ready);
   modport sink   (input valid, input operation, input point_x_mm, output ready);
endinterface

/* hw/rtl/kst_rsp_if.sv */
interface kst_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [kst_pkg::DATA_W-1:0]   avg_min_mm;
   logic signed [kst_pkg::DATA_W-1:0]   smallest_mm;

   modport source (output valid, output avg_min_mm, output smallest_mm, input ready);
   modport sink   (input valid, input avg_min_mm, input smallest_mm, output ready);
endinterface

/* hw/rtl/k_smallest_tracker.sv */
// k_smallest_tracker: keeps the KEEP_COUNT smallest signed distances (mm) seen
// on the request channel, in ascending order.
// Request channel req_chan: operation (insert or clear) and point_x_mm.
// Insert with a nonzero distance places it in sorted order after equal entries,
// dropping the largest; a zero distance leaves the list as is. Clear refills the
// list with sentinels 1e9 + 1000*index.
// Response channel rsp_chan: one response per request with the list mean
// (truncated toward zero) and the smallest entry, after the request applies.
// Timing: an accepted request passes through the scan, divider load, divide and
// write states and then the output register before the response shows valid.
// The list scan takes one compare/swap step per entry, then the mean divider
// produces eight quotient bits per cycle. One request is in work at a time;
// ready is high only when the sequencer is idle, so a new request is taken only
// once the previous one has left the write state.
// The response sits in an output register, so a new request is accepted while
// an earlier response still waits; a finished result waits in the sequencer
// until the output register frees up.
// Reset (synchronous, active high) loads the sentinels and empties the output.
module k_smallest_tracker (
   input logic       clock,
   input logic       reset,
   kst_req_if.sink   req_chan,
   kst_rsp_if.source rsp_chan
);

   kst_pkg::state_type                  state_ff, state_in;
   logic [kst_pkg::IDX_W-1:0]           idx_ff, idx_in;
   kst_pkg::list_ctrl_type              list_ctrl;
   logic                                div_start;
   logic                                div_done;
   logic                                load_out;
   logic                                last_idx;
   logic                                req_accept;
   logic signed [kst_pkg::SUM_W-1:0]    sum;
   logic signed [kst_pkg::DATA_W-1:0]   smallest;
   logic signed [kst_pkg::DATA_W-1:0]   mean;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [kst_pkg::DATA_W-1:0]   avg_ff, smallest_ff;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign last_idx   = (idx_ff == kst_pkg::IDX_W'(kst_pkg::KEEP_COUNT - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kst_pkg::ST_IDLE:     if (req_chan.valid) state_in = kst_pkg::ST_SCAN;
         kst_pkg::ST_SCAN:     if (last_idx) state_in = kst_pkg::ST_DIV_LOAD;
         kst_pkg::ST_DIV_LOAD: state_in = kst_pkg::ST_DIVIDE;
         kst_pkg::ST_DIVIDE:   if (div_done) state_in = kst_pkg::ST_WRITE;
         kst_pkg::ST_WRITE:    if (!rsp_valid_ff || rsp_chan.ready) state_in = kst_pkg::ST_IDLE;
         default:              state_in = kst_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_chan.ready  = 1'b0;
      list_ctrl.start = 1'b0;
      list_ctrl.step  = 1'b0;
      list_ctrl.idx   = idx_ff;
      div_start       = 1'b0;
      load_out        = 1'b0;
      idx_in          = idx_ff;
      unique case (state_ff)
         kst_pkg::ST_IDLE: begin
            req_chan.ready  = 1'b1;
            list_ctrl.start = req_chan.valid;
            idx_in          = '0;
         end
         kst_pkg::ST_SCAN: begin
            list_ctrl.step = 1'b1;
            idx_in         = last_idx ? '0 : idx_ff + 1'b1;
         end
         kst_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
         end
         kst_pkg::ST_DIVIDE: begin
         end
         kst_pkg::ST_WRITE: begin
            load_out = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kst_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   kst_list_unit u_list (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (list_ctrl),
      .operation  (req_chan.operation),
      .point_x_mm (req_chan.point_x_mm),
      .sum        (sum),
      .smallest   (smallest)
   );

   kst_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sum),
      .done  (div_done),
      .mean  (mean)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         avg_ff      <= mean;
         smallest_ff <= smallest;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.avg_min_mm  = avg_ff;
   assign rsp_chan.smallest_mm = smallest_ff;

   // an accepted request starts the list scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == kst_pkg::ST_SCAN))
      else $error("accepted request did not start the scan");

   // divider completion hands over to the write state
   a_div_write: assert property (@(posedge clock) disable iff (reset)
      div_done |=> (state_ff == kst_pkg::ST_WRITE))
      else $error("divider finished but no write followed");

   // a taken response with nothing behind it empties the output register
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !load_out) |=> !rsp_chan.valid)
      else $error("response repeated");

   // sorted list: the mean never falls below the smallest entry
   a_mean_order: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.smallest_mm <= rsp_chan.avg_min_mm))
      else $error("mean below smallest entry");

endmodule

/* hw/rtl/kst_list_unit.sv */
module kst_list_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  kst_pkg::list_ctrl_type              ctrl,
   input  logic                                operation,
   input  logic signed [kst_pkg::DATA_W-1:0]   point_x_mm,
   output logic signed [kst_pkg::SUM_W-1:0]    sum,
   output logic signed [kst_pkg::DATA_W-1:0]   smallest
);

   logic signed [kst_pkg::DATA_W-1:0] entries_ff [kst_pkg::KEEP_COUNT];
   logic signed [kst_pkg::DATA_W-1:0] entries_in [kst_pkg::KEEP_COUNT];
   logic signed [kst_pkg::DATA_W-1:0] carry_ff, carry_in;
   logic signed [kst_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                              active_ff, active_in;
   logic                              clear_ff, clear_in;
   logic signed [kst_pkg::DATA_W-1:0] cur;
   logic signed [kst_pkg::DATA_W-1:0] new_v;

   // one compare/swap and accumulate per step, walking up the list
   always_comb begin
      entries_in = entries_ff;
      carry_in   = carry_ff;
      active_in  = active_ff;
      clear_in   = clear_ff;
      sum_in     = sum_ff;
      cur        = entries_ff[ctrl.idx];
      new_v      = cur;
      if (ctrl.start) begin
         carry_in  = point_x_mm;
         active_in = (operation == kst_pkg::OP_INSERT) && (point_x_mm != '0);
         clear_in  = (operation == kst_pkg::OP_CLEAR);
         sum_in    = '0;
      end else if (ctrl.step) begin
         if (clear_ff) begin
            new_v = kst_pkg::sentinel(ctrl.idx);
         end else if (active_ff && (carry_ff < cur)) begin
            // new value goes here, displaced entry moves on down
            new_v    = carry_ff;
            carry_in = cur;
         end
         entries_in[ctrl.idx] = new_v;
         sum_in = sum_ff + kst_pkg::SUM_W'(new_v);
      end
   end

   // list storage, reset to sentinels
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < kst_pkg::KEEP_COUNT; i++) begin
            entries_ff[i] <= kst_pkg::sentinel(kst_pkg::IDX_W'(i));
         end
      end else begin
         entries_ff <= entries_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         clear_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         clear_ff  <= clear_in;
      end
      carry_ff <= carry_in;
      sum_ff   <= sum_in;
   end

   assign sum      = sum_ff;
   assign smallest = entries_ff[0];

endmodule

/* hw/rtl/kst_divider.sv */
module kst_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [kst_pkg::SUM_W-1:0]    sum,
   output logic                                done,
   output logic signed [kst_pkg::DATA_W-1:0]   mean
);

   logic [kst_pkg::DIVD_W-1:0] dvd_ff, dvd_in;
   logic [kst_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [kst_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       neg_ff, neg_in;
   logic [kst_pkg::SUM_W-1:0]  mag;
   logic [kst_pkg::REM_W:0]    trial;
   logic [kst_pkg::DATA_W-1:0] quot;

   assign mag = sum[kst_pkg::SUM_W-1] ? kst_pkg::SUM_W'(-sum) : kst_pkg::SUM_W'(sum);

   // restoring division by the list length, DIV_BITS bits per cycle;
   // quotient bits shift into the bottom of the dividend register
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      trial   = '0;
      if (start) begin
         dvd_in  = kst_pkg::DIVD_W'(mag);
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = sum[kst_pkg::SUM_W-1];
      end else if (busy_ff) begin
         for (int b = 0; b < kst_pkg::DIV_BITS; b++) begin
            trial  = {rem_in, dvd_in[kst_pkg::DIVD_W-1]};
            dvd_in = {dvd_in[kst_pkg::DIVD_W-2:0], 1'b0};
            if (trial >= (kst_pkg::REM_W + 1)'(kst_pkg::KEEP_COUNT)) begin
               rem_in    = kst_pkg::REM_W'(trial - (kst_pkg::REM_W + 1)'(kst_pkg::KEEP_COUNT));
               dvd_in[0] = 1'b1;
            end else begin
               rem_in = trial[kst_pkg::REM_W-1:0];
            end
         end
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done = busy_ff && (cnt_ff == kst_pkg::STEP_W'(kst_pkg::DIV_STEPS - 1));

   // sign restore gives truncation toward zero
   assign quot = dvd_ff[kst_pkg::DATA_W-1:0];
   assign mean = neg_ff ? -quot : quot;

endmodule
